/* src/rotation_matrix_to_quaternion_assert.svh */
// Assertion macros shared by the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rmq assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rmq assertion failed");

`endif

/* src/rmq_pkg.sv */
`timescale 1ns / 1ps
package rmq_pkg;

    localparam logic [1:0] PATH_TRACE = 2'd0;
    localparam logic [1:0] PATH_X     = 2'd1;
    localparam logic [1:0] PATH_Y     = 2'd2;
    localparam logic [1:0] PATH_Z     = 2'd3;

    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;

    // numerators per component (x, y, z, w), dominant one-hot, branch
    typedef struct packed {
        logic [3:0][17:0] num;
        logic [3:0]       dom;
        logic [1:0]       path;
    } rmq_side_t;

endpackage

/* src/rmq_in_if.sv */
`timescale 1ns / 1ps
interface rmq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] row0_col0;
    logic signed [15:0] row0_col1;
    logic signed [15:0] row0_col2;
    logic signed [15:0] row1_col0;
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row2_col0;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;

    modport source (
        output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
               row1_col2, row2_col0, row2_col1, row2_col2,
        input  ready
    );
    modport sink (
        input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
               row1_col2, row2_col0, row2_col1, row2_col2,
        output ready
    );
endinterface

/* src/rmq_out_if.sv */
`timescale 1ns / 1ps
interface rmq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0]         path_taken;
    logic               range_error;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, path_taken, range_error,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, path_taken, range_error,
        output ready
    );
endinterface

/* src/rmq_front.sv */
`timescale 1ns / 1ps
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int RW        = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [14:0]       trace_threshold,
    rmq_in_if.sink            mtx,
    output logic              out_valid,
    output logic signed [RW-1:0] out_r,
    output rmq_pkg::rmq_side_t out_side
);
    import rmq_pkg::*;

    localparam logic signed [RW-1:0] ONE =
        {{(RW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [RW-1:0] a00, a11, a22, thr, t, r_next;
    logic signed [17:0]   e01, e02, e10, e12, e20, e21;
    rmq_side_t            side_next;
    logic                 valid_reg;
    logic signed [RW-1:0] r_reg;
    rmq_side_t            side_reg;

    assign mtx.ready = en;

    assign a00 = RW'(mtx.row0_col0);
    assign a11 = RW'(mtx.row1_col1);
    assign a22 = RW'(mtx.row2_col2);
    assign e01 = 18'(mtx.row0_col1);
    assign e02 = 18'(mtx.row0_col2);
    assign e10 = 18'(mtx.row1_col0);
    assign e12 = 18'(mtx.row1_col2);
    assign e20 = 18'(mtx.row2_col0);
    assign e21 = 18'(mtx.row2_col1);
    assign thr = RW'($signed({1'b0, trace_threshold}));
    assign t   = ONE + a00 + a11 + a22;

    always_comb
    begin
        side_next.num = '0;
        if (t > thr)
        begin
            side_next.path   = PATH_TRACE;
            side_next.dom    = 4'b1000;
            r_next           = t;
            side_next.num[0] = e12 - e21;
            side_next.num[1] = e20 - e02;
            side_next.num[2] = e01 - e10;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            side_next.path   = PATH_X;
            side_next.dom    = 4'b0001;
            r_next           = ONE + a00 - a11 - a22;
            side_next.num[1] = e01 + e10;
            side_next.num[2] = e20 + e02;
            side_next.num[3] = e12 - e21;
        end
        else if (a11 > a22)
        begin
            side_next.path   = PATH_Y;
            side_next.dom    = 4'b0010;
            r_next           = ONE + a11 - a00 - a22;
            side_next.num[0] = e01 + e10;
            side_next.num[2] = e12 + e21;
            side_next.num[3] = e20 - e02;
        end
        else
        begin
            side_next.path   = PATH_Z;
            side_next.dom    = 4'b0100;
            r_next           = ONE + a22 - a00 - a11;
            side_next.num[0] = e20 + e02;
            side_next.num[1] = e12 + e21;
            side_next.num[3] = e01 - e10;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= mtx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;
endmodule

/* src/rmq_sqrt.sv */
`timescale 1ns / 1ps
module rmq_sqrt #(
    parameter int FRAC_BITS = 14,
    parameter int RW        = 20,
    parameter int SW        = 18
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [RW-1:0] in_r,
    input  rmq_pkg::rmq_side_t   in_side,
    output logic                 out_valid,
    output logic [SW:0]          out_s,
    output rmq_pkg::rmq_side_t   out_side
);
    import rmq_pkg::*;

    localparam int NWE = 2 * SW;
    localparam int RMW = SW + 3;

    logic [NWE-1:0] n_in;
    logic [NWE-1:0] n_cur    [0:SW-1];
    logic [RMW-1:0] rem_cur  [0:SW-1];
    logic [SW-1:0]  root_cur [0:SW-1];
    logic           v_cur    [0:SW-1];
    rmq_side_t      side_cur [0:SW-1];

    logic [NWE-1:0] n_reg    [1:SW];
    logic [RMW-1:0] rem_reg  [1:SW];
    logic [SW-1:0]  root_reg [1:SW];
    logic           v_reg    [1:SW];
    rmq_side_t      side_reg [1:SW];

    logic           v_out_reg;
    logic [SW:0]    s_reg;
    rmq_side_t      side_out_reg;

    // non-positive radicand gives s = 0
    assign n_in = (in_r > 0) ? (NWE'($unsigned(in_r)) << (FRAC_BITS + 2)) : '0;

    for (genvar i = 0; i < SW; i++)
    begin : g_step
        logic [RMW-1:0] rem_t, trial;
        logic           take;

        if (i == 0)
        begin : g_first
            assign n_cur[i]    = n_in;
            assign rem_cur[i]  = '0;
            assign root_cur[i] = '0;
            assign v_cur[i]    = in_valid;
            assign side_cur[i] = in_side;
        end
        else
        begin : g_next
            assign n_cur[i]    = n_reg[i];
            assign rem_cur[i]  = rem_reg[i];
            assign root_cur[i] = root_reg[i];
            assign v_cur[i]    = v_reg[i];
            assign side_cur[i] = side_reg[i];
        end

        assign rem_t = {rem_cur[i][RMW-3:0], n_cur[i][2*(SW-1-i)+1 -: 2]};
        assign trial = RMW'({root_cur[i], 2'b01});
        assign take  = rem_t >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_cur[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i+1]    <= n_cur[i];
                rem_reg[i+1]  <= take ? rem_t - trial : rem_t;
                root_reg[i+1] <= {root_cur[i][SW-2:0], take};
                side_reg[i+1] <= side_cur[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out_reg <= 1'b0;
        else if (en)
            v_out_reg <= v_reg[SW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= (rem_reg[SW] > RMW'(root_reg[SW])) ?
                     (SW+1)'(root_reg[SW]) + 1'b1 : (SW+1)'(root_reg[SW]);
            side_out_reg <= side_reg[SW];
        end
    end

    assign out_valid = v_out_reg;
    assign out_s     = s_reg;
    assign out_side  = side_out_reg;
endmodule

/* src/rmq_div.sv */
`timescale 1ns / 1ps
module rmq_div #(
    parameter int FRAC_BITS = 14,
    parameter int SW        = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [SW:0]        in_s,
    input  rmq_pkg::rmq_side_t in_side,
    output logic               en,
    rmq_out_if.source          quat
);
    import rmq_pkg::*;

    localparam int S1 = SW + 1;
    localparam int CW = FRAC_BITS + S1 + 20;
    localparam int QB = 16;

    logic [CW-1:0] s_w, dd_e, dv;
    logic          dv_sat;
    logic [CW-1:0] nn_e   [0:3];
    logic          neg_e  [0:3];
    logic          ovf_e  [0:3];
    logic          spec_e [0:3];
    logic [15:0]   fixv_e [0:3];
    logic          fixe_e [0:3];

    logic [CW-1:0] rem_reg  [0:3][0:QB];
    logic [15:0]   q_reg    [0:3][0:QB];
    logic          neg_reg  [0:3][0:QB];
    logic          ovf_reg  [0:3][0:QB];
    logic          spec_reg [0:3][0:QB];
    logic [15:0]   fixv_reg [0:3][0:QB];
    logic          fixe_reg [0:3][0:QB];
    logic [CW-1:0] dd_reg   [0:QB];
    logic [1:0]    path_reg [0:QB];
    logic          v_reg    [0:QB];

    logic [15:0]   res_next [0:3];
    logic [3:0]    err_next;
    logic [15:0]   res_reg  [0:3];
    logic          err_reg;
    logic [1:0]    path_out_reg;
    logic          v_out_reg;

    assign en = !v_out_reg || quat.ready;

    assign s_w    = CW'(in_s);
    assign dd_e   = s_w << 1;
    assign dv     = (s_w + CW'(2)) >> 2;
    assign dv_sat = dv > CW'(Q_MAX);

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            neg_e[l]  = in_side.num[l][17];
            nn_e[l]   = (CW'(neg_e[l] ? 18'(-$signed(in_side.num[l])) : in_side.num[l])
                        << (FRAC_BITS + 1)) + s_w;
            ovf_e[l]  = nn_e[l] >= (dd_e << QB);
            spec_e[l] = in_side.dom[l] || (in_s == '0);
            if (in_side.dom[l])
            begin
                fixv_e[l] = dv_sat ? Q_MAX : dv[15:0];
                fixe_e[l] = dv_sat;
            end
            else
            begin
                fixe_e[l] = 1'b1;
                if (neg_e[l])
                    fixv_e[l] = Q_MIN;
                else if (in_side.num[l] != '0)
                    fixv_e[l] = Q_MAX;
                else
                    fixv_e[l] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0]   <= dd_e;
            path_reg[0] <= in_side.path;
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane_in
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[l][0]  <= nn_e[l];
                q_reg[l][0]    <= '0;
                neg_reg[l][0]  <= neg_e[l];
                ovf_reg[l][0]  <= ovf_e[l];
                spec_reg[l][0] <= spec_e[l];
                fixv_reg[l][0] <= fixv_e[l];
                fixe_reg[l][0] <= fixe_e[l];
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [CW-1:0] sub;
        assign sub = dd_reg[k] << (QB - 1 - k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[k+1]   <= dd_reg[k];
                path_reg[k+1] <= path_reg[k];
            end
        end

        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_reg[l][k] >= sub)
                    begin
                        rem_reg[l][k+1] <= rem_reg[l][k] - sub;
                        q_reg[l][k+1]   <= q_reg[l][k] | (16'd1 << (QB - 1 - k));
                    end
                    else
                    begin
                        rem_reg[l][k+1] <= rem_reg[l][k];
                        q_reg[l][k+1]   <= q_reg[l][k];
                    end
                    neg_reg[l][k+1]  <= neg_reg[l][k];
                    ovf_reg[l][k+1]  <= ovf_reg[l][k];
                    spec_reg[l][k+1] <= spec_reg[l][k];
                    fixv_reg[l][k+1] <= fixv_reg[l][k];
                    fixe_reg[l][k+1] <= fixe_reg[l][k];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (spec_reg[l][QB])
            begin
                res_next[l] = fixv_reg[l][QB];
                err_next[l] = fixe_reg[l][QB];
            end
            else if (neg_reg[l][QB])
            begin
                if (ovf_reg[l][QB] || ({1'b0, q_reg[l][QB]} > 17'd32768))
                begin
                    res_next[l] = Q_MIN;
                    err_next[l] = 1'b1;
                end
                else
                begin
                    res_next[l] = 16'(-q_reg[l][QB]);
                    err_next[l] = 1'b0;
                end
            end
            else if (ovf_reg[l][QB] || q_reg[l][QB][15])
            begin
                res_next[l] = Q_MAX;
                err_next[l] = 1'b1;
            end
            else
            begin
                res_next[l] = q_reg[l][QB];
                err_next[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out_reg <= 1'b0;
        else if (en)
            v_out_reg <= v_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
                res_reg[l] <= res_next[l];
            err_reg      <= |err_next;
            path_out_reg <= path_reg[QB];
        end
    end

    assign quat.valid       = v_out_reg;
    assign quat.quat_x      = res_reg[0];
    assign quat.quat_y      = res_reg[1];
    assign quat.quat_z      = res_reg[2];
    assign quat.quat_w      = res_reg[3];
    assign quat.path_taken  = path_out_reg;
    assign quat.range_error = err_reg;
endmodule

/* src/rotation_matrix_to_quaternion.sv */
// Rotation matrix to quaternion (Shepperd's method), fully pipelined: one
// matrix request is taken every cycle while the output is not stalled. The
// square root resolves SW = ceil((RW + FRAC_BITS + 2) / 2) root bits, where
// RW = max(FRAC_BITS, 17) + 3, one root bit per stage; the four-lane divider
// resolves one quotient bit per stage. The whole pipeline holds while an
// output request waits; in.ready is high in the same cycle when out.ready
// is high or the output is empty. trace_threshold is written through
// cfg_we/cfg_wdata while idle; the user must ensure this, it is unchecked.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    rmq_in_if.sink      mtx,
    rmq_out_if.source   quat
);
    import rmq_pkg::*;

    `include "rotation_matrix_to_quaternion_assert.svh"

    localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int SW = (RW + FRAC_BITS + 3) / 2;

    logic                 en;
    logic [14:0]          thr_reg;
    logic                 f_valid, s_valid;
    logic signed [RW-1:0] f_r;
    rmq_side_t            f_side, s_side;
    logic [SW:0]          s_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .trace_threshold (thr_reg),
        .mtx             (mtx),
        .out_valid       (f_valid),
        .out_r           (f_r),
        .out_side        (f_side)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .RW(RW), .SW(SW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_r      (f_r),
        .in_side   (f_side),
        .out_valid (s_valid),
        .out_s     (s_val),
        .out_side  (s_side)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_valid),
        .in_s     (s_val),
        .in_side  (s_side),
        .en       (en),
        .quat     (quat)
    );

    // dominant component is s/4 rounded, saturated at Q_MAX, never negative
    `RMQ_ASSERT_IMP(a_dom_w, clk, rst_n, quat.valid && quat.path_taken == PATH_TRACE, !quat.quat_w[15])
    `RMQ_ASSERT_IMP(a_dom_x, clk, rst_n, quat.valid && quat.path_taken == PATH_X, !quat.quat_x[15])
    `RMQ_ASSERT_IMP(a_dom_y, clk, rst_n, quat.valid && quat.path_taken == PATH_Y, !quat.quat_y[15])
    `RMQ_ASSERT_IMP(a_dom_z, clk, rst_n, quat.valid && quat.path_taken == PATH_Z, !quat.quat_z[15])
    `RMQ_ASSERT_NXT(a_rst_empty, clk, rst_n, $rose(rst_n), !quat.valid)
endmodule
